>>> hdl/icatt_pkg.sv
`default_nettype none

package icatt_pkg;

   // Default number of fractional bits of every angle.
   localparam int ANGLE_FRAC_BITS_DEF = 16;

   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_FRAC  = 24;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 38;
   localparam int MUL_B_W = 33;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Width of the internal working word for shifts and saturation.
   localparam int WIDE_W = 72;

   localparam logic signed [MUL_B_W-1:0] PI_OVER_180_Q32 = 33'sd74961321;
   localparam logic signed [WIDE_W-1:0]  YAW_DEG_LIMIT   = 72'sd64424509440;
   localparam logic signed [WIDE_W-1:0]  ONE_Q30         = 72'sd1073741824;
   localparam logic [24:0]               WEIGHT_ONE      = 25'd16777216;
   // ceil(2^33 / 6): exact quotient for dividends below 2^31.
   localparam logic signed [MUL_B_W-1:0] DIV6_RECIP      = 33'sd1431655766;
   localparam int                        DIV6_SHIFT      = 33;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OFFSET_PITCH = 3'd0;
   localparam logic [2:0] CSR_OFFSET_ROLL  = 3'd1;
   localparam logic [2:0] CSR_OFFSET_YAW   = 3'd2;
   localparam logic [2:0] CSR_GYRO_GAIN    = 3'd3;
   localparam logic [2:0] CSR_ACCEL_WEIGHT = 3'd4;
   localparam logic [2:0] CSR_PITCH_TRIM   = 3'd5;
   localparam logic [2:0] CSR_ROLL_TRIM    = 3'd6;

   localparam logic [31:0] GYRO_GAIN_RST    = 32'd262423;
   localparam logic [24:0] ACCEL_WEIGHT_RST = 25'd6711;
   localparam logic [31:0] PITCH_TRIM_RST   = 32'd78643;
   localparam logic [31:0] ROLL_TRIM_RST    = 32'd72090;

   // Arctangent of 2^-i in degrees, 24 fractional bits.
   function automatic logic [29:0] atan_deg_q24(input logic [4:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd754974720;
         5'd1:  v = 30'd445687602;
         5'd2:  v = 30'd235489089;
         5'd3:  v = 30'd119537938;
         5'd4:  v = 30'd60000934;
         5'd5:  v = 30'd30029717;
         5'd6:  v = 30'd15018523;
         5'd7:  v = 30'd7509720;
         5'd8:  v = 30'd3754917;
         5'd9:  v = 30'd1877466;
         5'd10: v = 30'd938734;
         5'd11: v = 30'd469367;
         5'd12: v = 30'd234684;
         5'd13: v = 30'd117342;
         5'd14: v = 30'd58671;
         5'd15: v = 30'd29335;
         5'd16: v = 30'd14668;
         5'd17: v = 30'd7334;
         5'd18: v = 30'd3667;
         5'd19: v = 30'd1833;
         5'd20: v = 30'd917;
         5'd21: v = 30'd458;
         5'd22: v = 30'd229;
         5'd23: v = 30'd115;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Right shift that rounds half toward plus infinity.
   function automatic logic signed [WIDE_W-1:0] round_shift(
      input logic signed [WIDE_W-1:0] x, input int unsigned s);
      logic signed [WIDE_W-1:0] one;
      one = 72'sd1;
      if (s == 0) begin
         return x;
      end
      return (x + (one <<< (s - 1))) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] x);
      if (x > 72'sd2147483647) begin
         return 32'sh7fffffff;
      end
      if (x < -72'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/icatt_mul.sv
`default_nettype none

module icatt_mul (
   input  wire logic                                  clock,
   input  wire logic signed [icatt_pkg::MUL_A_W-1:0]  a,
   input  wire logic signed [icatt_pkg::MUL_B_W-1:0]  b,
   output logic signed [icatt_pkg::MUL_P_W-1:0]       p
);
   import icatt_pkg::*;

   logic signed [MUL_P_W-1:0] p_ff;

   // The product is registered; it is valid in the cycle after the operands.
   always_ff @(posedge clock) begin
      p_ff <= MUL_P_W'(a) * MUL_P_W'(b);
   end

   assign p = p_ff;

endmodule

`default_nettype wire

>>> hdl/icatt_isqrt.sv
`default_nettype none

module icatt_isqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] value,
   output logic             done,
   output logic [31:0]      root
);
   import icatt_pkg::*;

   logic [63:0] v_ff, v_in;
   logic [63:0] r_ff, r_in;
   logic [4:0]  k_ff, k_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [63:0] bit_w;
   logic [63:0] trial;

   // One result bit per cycle.
   assign bit_w = 64'd1 << {k_ff, 1'b0};
   assign trial = r_ff + bit_w;

   always_comb begin
      v_in    = v_ff;
      r_in    = r_ff;
      k_in    = k_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = value;
         r_in    = '0;
         k_in    = 5'd31;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_w;
         end else begin
            r_in = r_ff >> 1;
         end
         k_in = k_ff - 5'd1;
         if (k_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
      k_ff <= k_in;
   end

   assign done = done_ff;
   assign root = r_ff[31:0];

endmodule

`default_nettype wire

>>> hdl/icatt_cordic.sv
`default_nettype none

module icatt_cordic (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [29:0] num,
   input  wire logic [31:0]        den,
   output logic                    done,
   output logic signed [33:0]      angle
);
   import icatt_pkg::*;

   logic signed [34:0] x_ff, x_in;
   logic signed [34:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [4:0]         i_ff, i_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic signed [34:0] sx, sy;
   logic signed [33:0] step_ang;

   // Vectoring mode: drive y to zero, accumulate the angle in degrees.
   assign sx       = x_ff >>> i_ff;
   assign sy       = y_ff >>> i_ff;
   assign step_ang = 34'(atan_deg_q24(i_ff));

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      i_in    = i_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = 35'(den);
         y_in    = 35'(num);
         z_in    = '0;
         i_in    = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff >= 0) begin
            x_in = x_ff + sy;
            y_in = y_ff - sx;
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - sy;
            y_in = y_ff + sx;
            z_in = z_ff - step_ang;
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      i_ff <= i_in;
   end

   assign done  = done_ff;
   assign angle = z_ff;

endmodule

`default_nettype wire

>>> hdl/imu_complementary_attitude.sv
// Channel  Direction  Handshake                 Payload
// req      in         req_tvalid / req_tready   tdata: six raw samples, tuser: apply_offsets
// rsp      out        rsp_tvalid / rsp_tready   tdata: pitch_angle, roll_angle
// csr      in         csr_valid / csr_ready     csr_index, csr_data
//
// A request occupies the block from its acceptance until its result is written.
// The 32-step square root and the 24-step CORDIC run once per accel angle and
// take most of that time; an angle with a degenerate vector skips both. The
// multiplier chain (accel squares, then the gyro part) has 19 steps on one
// shared registered multiplier. Reset is synchronous and clears the estimates,
// the held accel angles and the registers to their defaults. A result waits in
// the output register; a new request is taken while it waits, and the block
// holds its final step only if the previous result is still not taken.
`default_nettype none

module imu_complementary_attitude #(
   parameter int ANGLE_FRAC_BITS = icatt_pkg::ANGLE_FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // rate_x[15:0], rate_y[31:16], rate_z[47:32], acc_x[63:48], acc_y[79:64], acc_z[95:80]
   input  wire logic [95:0] req_tdata,
   // apply_offsets[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // pitch_angle[31:0], roll_angle[63:32]
   output logic [63:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import icatt_pkg::*;

   // Sequencer states. The M states walk the multiplier chain: each one takes
   // the product issued by the state before, issues the next, or does both.
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_M0   = 5'd1;
   localparam logic [4:0] ST_M1   = 5'd2;
   localparam logic [4:0] ST_M2   = 5'd3;
   localparam logic [4:0] ST_M3   = 5'd4;
   localparam logic [4:0] ST_M4   = 5'd5;
   localparam logic [4:0] ST_M5   = 5'd6;
   localparam logic [4:0] ST_M6   = 5'd7;
   localparam logic [4:0] ST_M7   = 5'd8;
   localparam logic [4:0] ST_M8   = 5'd9;
   localparam logic [4:0] ST_M9   = 5'd10;
   localparam logic [4:0] ST_M10  = 5'd11;
   localparam logic [4:0] ST_M11  = 5'd12;
   localparam logic [4:0] ST_M12  = 5'd13;
   localparam logic [4:0] ST_M13  = 5'd14;
   localparam logic [4:0] ST_M14  = 5'd15;
   localparam logic [4:0] ST_M15  = 5'd16;
   localparam logic [4:0] ST_M16  = 5'd17;
   localparam logic [4:0] ST_M17  = 5'd18;
   localparam logic [4:0] ST_M18  = 5'd19;
   localparam logic [4:0] ST_A0   = 5'd20;
   localparam logic [4:0] ST_A1   = 5'd21;
   localparam logic [4:0] ST_A2   = 5'd22;
   localparam logic [4:0] ST_B0   = 5'd23;
   localparam logic [4:0] ST_B1   = 5'd24;
   localparam logic [4:0] ST_B2   = 5'd25;
   localparam logic [4:0] ST_B3   = 5'd26;
   localparam logic [4:0] ST_B4   = 5'd27;

   localparam int unsigned GYRO_SHIFT  = 40 - ANGLE_FRAC_BITS;
   localparam int unsigned ANGLE_SHIFT = CORDIC_FRAC - ANGLE_FRAC_BITS;

   // Configuration registers.
   logic signed [23:0] off_pitch_ff, off_roll_ff, off_yaw_ff;
   logic [31:0]        gain_ff;
   logic [24:0]        weight_ff;
   logic signed [31:0] pitch_trim_ff, roll_trim_ff;

   // Persistent state.
   logic signed [31:0] pitch_est_ff, pitch_est_in;
   logic signed [31:0] roll_est_ff, roll_est_in;
   logic signed [31:0] acc_pitch_ff, acc_pitch_in;
   logic signed [31:0] acc_roll_ff, acc_roll_in;

   // Per-request working registers.
   logic [4:0]         state_ff, state_in;
   logic signed [25:0] p_ff, p_in, r_ff, r_in, y_ff, y_in;
   logic signed [15:0] ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   logic [31:0]        sqx_ff, sqx_in, sqy_ff, sqy_in, sqz_ff, sqz_in;
   logic signed [31:0] pitch_ff, pitch_in, roll_ff, roll_in;
   logic signed [37:0] deg_ff, deg_in;
   logic signed [31:0] th_ff, th_in, t_ff, t_in, sn_ff, sn_in;
   logic signed [37:0] t3abs_ff, t3abs_in;
   logic               t3neg_ff, t3neg_in;
   logic               axis_ff, axis_in;
   logic signed [MUL_P_W-1:0] mix_ff, mix_in;
   logic signed [31:0] blend_p_ff, blend_p_in, blend_r_ff, blend_r_in;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        rsp_data_ff, rsp_data_in;

   // Shared units.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic                      sq_start, sq_done;
   logic [31:0]               sq_root;
   logic [31:0]               sq_sum;
   logic                      co_start, co_done;
   logic signed [29:0]        co_num;
   logic signed [33:0]        co_angle;

   logic                      req_fire;
   logic signed [25:0]        rate_x_s, rate_y_s, rate_z_s;
   logic [24:0]               w_clamp;
   logic signed [MUL_B_W-1:0] gain_s, w_s, w_rest_s;
   logic signed [WIDE_W-1:0]  prod;
   logic signed [31:0]        co_deg;

   icatt_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   icatt_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sq_start),
      .value ({32'd0, sq_sum} << 28),
      .done  (sq_done),
      .root  (sq_root)
   );

   icatt_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (co_start),
      .num   (co_num),
      .den   (sq_root),
      .done  (co_done),
      .angle (co_angle)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Raw rates scaled to 8 fractional bits.
   assign rate_x_s = {{2{req_tdata[15]}}, req_tdata[15:0], 8'd0};
   assign rate_y_s = {{2{req_tdata[31]}}, req_tdata[31:16], 8'd0};
   assign rate_z_s = {{2{req_tdata[47]}}, req_tdata[47:32], 8'd0};

   // Weights beyond one act as one.
   assign w_clamp  = (weight_ff > WEIGHT_ONE) ? WEIGHT_ONE : weight_ff;
   assign gain_s   = MUL_B_W'({1'b0, gain_ff});
   assign w_s      = MUL_B_W'({1'b0, w_clamp});
   assign w_rest_s = MUL_B_W'({1'b0, WEIGHT_ONE - w_clamp});

   assign prod   = WIDE_W'(mul_p);
   // Pitch tilt uses the X and Z axes against Y; roll uses Y and Z against X.
   assign sq_sum = axis_ff ? (sqy_ff + sqz_ff) : (sqx_ff + sqz_ff);
   assign co_num = axis_ff ? {ax_ff, 14'd0} : {ay_ff, 14'd0};
   assign co_deg = sat32(round_shift(WIDE_W'(co_angle), ANGLE_SHIFT));

   always_comb begin
      logic signed [WIDE_W-1:0] tmp;
      logic signed [WIDE_W-1:0] t3;
      logic signed [WIDE_W-1:0] q;

      state_in     = state_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      y_in         = y_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      az_in        = az_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      sqz_in       = sqz_ff;
      pitch_in     = pitch_ff;
      roll_in      = roll_ff;
      deg_in       = deg_ff;
      th_in        = th_ff;
      t_in         = t_ff;
      sn_in        = sn_ff;
      t3abs_in     = t3abs_ff;
      t3neg_in     = t3neg_ff;
      axis_in      = axis_ff;
      mix_in       = mix_ff;
      blend_p_in   = blend_p_ff;
      blend_r_in   = blend_r_ff;
      pitch_est_in = pitch_est_ff;
      roll_est_in  = roll_est_ff;
      acc_pitch_in = acc_pitch_ff;
      acc_roll_in  = acc_roll_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      sq_start     = 1'b0;
      co_start     = 1'b0;
      tmp          = '0;
      t3           = '0;
      q            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // Yaw rate is the negated Z rate.
               p_in    = rate_x_s - (req_tuser[0] ? 26'(off_pitch_ff) : 26'sd0);
               r_in    = rate_y_s - (req_tuser[0] ? 26'(off_roll_ff) : 26'sd0);
               y_in    = -rate_z_s - (req_tuser[0] ? 26'(off_yaw_ff) : 26'sd0);
               ax_in   = req_tdata[63:48];
               ay_in   = req_tdata[79:64];
               az_in   = req_tdata[95:80];
               axis_in = 1'b0;
               state_in = ST_M0;
            end
         end
         ST_M0: begin
            mul_a    = MUL_A_W'(ax_ff);
            mul_b    = MUL_B_W'(ax_ff);
            state_in = ST_M1;
         end
         ST_M1: begin
            sqx_in   = prod[31:0];
            mul_a    = MUL_A_W'(ay_ff);
            mul_b    = MUL_B_W'(ay_ff);
            state_in = ST_M2;
         end
         ST_M2: begin
            sqy_in   = prod[31:0];
            mul_a    = MUL_A_W'(az_ff);
            mul_b    = MUL_B_W'(az_ff);
            state_in = ST_M3;
         end
         ST_M3: begin
            sqz_in   = prod[31:0];
            mul_a    = MUL_A_W'(p_ff);
            mul_b    = gain_s;
            state_in = ST_M4;
         end
         ST_M4: begin
            pitch_in = sat32(WIDE_W'(pitch_est_ff) + round_shift(prod, GYRO_SHIFT));
            mul_a    = MUL_A_W'(r_ff);
            mul_b    = gain_s;
            state_in = ST_M5;
         end
         ST_M5: begin
            roll_in  = sat32(WIDE_W'(roll_est_ff) + round_shift(prod, GYRO_SHIFT));
            mul_a    = MUL_A_W'(y_ff);
            mul_b    = gain_s;
            state_in = ST_M6;
         end
         ST_M6: begin
            // Yaw step in degrees, Q30, limited to plus or minus 60.
            tmp = round_shift(prod, 10);
            if (tmp > YAW_DEG_LIMIT) begin
               tmp = YAW_DEG_LIMIT;
            end else if (tmp < -YAW_DEG_LIMIT) begin
               tmp = -YAW_DEG_LIMIT;
            end
            deg_in   = tmp[37:0];
            state_in = ST_M7;
         end
         ST_M7: begin
            mul_a    = deg_ff;
            mul_b    = PI_OVER_180_Q32;
            state_in = ST_M8;
         end
         ST_M8: begin
            // Angle in radians, Q2.30, limited to plus or minus one.
            tmp = round_shift(prod, 32);
            if (tmp > ONE_Q30) begin
               tmp = ONE_Q30;
            end else if (tmp < -ONE_Q30) begin
               tmp = -ONE_Q30;
            end
            th_in    = tmp[31:0];
            state_in = ST_M9;
         end
         ST_M9: begin
            mul_a    = MUL_A_W'(th_ff);
            mul_b    = MUL_B_W'(th_ff);
            state_in = ST_M10;
         end
         ST_M10: begin
            tmp      = round_shift(prod, 30);
            t_in     = tmp[31:0];
            state_in = ST_M11;
         end
         ST_M11: begin
            mul_a    = MUL_A_W'(t_ff);
            mul_b    = MUL_B_W'(th_ff);
            state_in = ST_M12;
         end
         ST_M12: begin
            // The cube divided by six truncates toward zero, so the
            // division works on the magnitude.
            t3       = round_shift(prod, 30);
            t3neg_in = t3 < 0;
            tmp      = (t3 < 0) ? -t3 : t3;
            t3abs_in = tmp[37:0];
            state_in = ST_M13;
         end
         ST_M13: begin
            mul_a    = t3abs_ff;
            mul_b    = DIV6_RECIP;
            state_in = ST_M14;
         end
         ST_M14: begin
            q        = prod >>> DIV6_SHIFT;
            if (t3neg_ff) begin
               q = -q;
            end
            tmp      = WIDE_W'(th_ff) - q;
            sn_in    = tmp[31:0];
            state_in = ST_M15;
         end
         ST_M15: begin
            mul_a    = MUL_A_W'(roll_ff);
            mul_b    = MUL_B_W'(sn_ff);
            state_in = ST_M16;
         end
         ST_M16: begin
            // Pitch takes the yaw coupling first; roll then uses the new pitch.
            pitch_in = sat32(WIDE_W'(pitch_ff) - round_shift(prod, 30));
            state_in = ST_M17;
         end
         ST_M17: begin
            mul_a    = MUL_A_W'(pitch_ff);
            mul_b    = MUL_B_W'(sn_ff);
            state_in = ST_M18;
         end
         ST_M18: begin
            roll_in  = sat32(WIDE_W'(roll_ff) + round_shift(prod, 30));
            state_in = ST_A0;
         end
         ST_A0: begin
            // With both other axes zero the held accel angle stays.
            if (sq_sum != 32'd0) begin
               sq_start = 1'b1;
               state_in = ST_A1;
            end else if (axis_ff) begin
               state_in = ST_B0;
            end else begin
               axis_in = 1'b1;
            end
         end
         ST_A1: begin
            if (sq_done) begin
               co_start = 1'b1;
               state_in = ST_A2;
            end
         end
         ST_A2: begin
            if (co_done) begin
               if (axis_ff) begin
                  acc_roll_in = sat32(-WIDE_W'(co_deg));
                  state_in    = ST_B0;
               end else begin
                  acc_pitch_in = co_deg;
                  axis_in      = 1'b1;
                  state_in     = ST_A0;
               end
            end
         end
         ST_B0: begin
            // The trim enters the blend only and never the held angle.
            blend_p_in = sat32(WIDE_W'(acc_pitch_ff) + WIDE_W'(pitch_trim_ff));
            blend_r_in = sat32(WIDE_W'(acc_roll_ff) + WIDE_W'(roll_trim_ff));
            mul_a      = MUL_A_W'(pitch_ff);
            mul_b      = w_rest_s;
            state_in   = ST_B1;
         end
         ST_B1: begin
            mix_in   = mul_p;
            mul_a    = MUL_A_W'(blend_p_ff);
            mul_b    = w_s;
            state_in = ST_B2;
         end
         ST_B2: begin
            pitch_est_in = sat32(round_shift(WIDE_W'(mix_ff) + prod, 24));
            mul_a        = MUL_A_W'(roll_ff);
            mul_b        = w_rest_s;
            state_in     = ST_B3;
         end
         ST_B3: begin
            mix_in   = mul_p;
            mul_a    = MUL_A_W'(blend_r_ff);
            mul_b    = w_s;
            state_in = ST_B4;
         end
         ST_B4: begin
            // Keep the operands so the product holds while the output waits.
            mul_a = MUL_A_W'(blend_r_ff);
            mul_b = w_s;
            if (!rsp_valid_ff || rsp_tready) begin
               roll_est_in  = sat32(round_shift(WIDE_W'(mix_ff) + prod, 24));
               rsp_data_in  = {roll_est_in, pitch_est_ff};
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         pitch_est_ff  <= '0;
         roll_est_ff   <= '0;
         acc_pitch_ff  <= '0;
         acc_roll_ff   <= '0;
         off_pitch_ff  <= '0;
         off_roll_ff   <= '0;
         off_yaw_ff    <= '0;
         gain_ff       <= GYRO_GAIN_RST;
         weight_ff     <= ACCEL_WEIGHT_RST;
         pitch_trim_ff <= PITCH_TRIM_RST;
         roll_trim_ff  <= ROLL_TRIM_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pitch_est_ff <= pitch_est_in;
         roll_est_ff  <= roll_est_in;
         acc_pitch_ff <= acc_pitch_in;
         acc_roll_ff  <= acc_roll_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_OFFSET_PITCH: off_pitch_ff  <= csr_data[23:0];
               CSR_OFFSET_ROLL:  off_roll_ff   <= csr_data[23:0];
               CSR_OFFSET_YAW:   off_yaw_ff    <= csr_data[23:0];
               CSR_GYRO_GAIN:    gain_ff       <= csr_data;
               CSR_ACCEL_WEIGHT: weight_ff     <= csr_data[24:0];
               CSR_PITCH_TRIM:   pitch_trim_ff <= csr_data;
               CSR_ROLL_TRIM:    roll_trim_ff  <= csr_data;
               default: begin
               end
            endcase
         end
      end
      p_ff        <= p_in;
      r_ff        <= r_in;
      y_ff        <= y_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      az_ff       <= az_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      sqz_ff      <= sqz_in;
      pitch_ff    <= pitch_in;
      roll_ff     <= roll_in;
      deg_ff      <= deg_in;
      th_ff       <= th_in;
      t_ff        <= t_in;
      sn_ff       <= sn_in;
      t3abs_ff    <= t3abs_in;
      t3neg_ff    <= t3neg_in;
      axis_ff     <= axis_in;
      mix_ff      <= mix_in;
      blend_p_ff  <= blend_p_in;
      blend_r_ff  <= blend_r_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> hdl/icatt_chk.sv
`default_nettype none

module icatt_chk (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata
);

   // A waiting result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The block works on one request at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // A result appears only at the end of a request's work.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response without a request in flight");

   // Reset leaves the block idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("block not idle after reset");

endmodule

bind imu_complementary_attitude icatt_chk u_icatt_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
